// File: design/unique_key_set_table_defines.svh
// Assertion macros for the unique key set table.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UNIQUE_KEY_SET_TABLE_DEFINES_SVH
`define UNIQUE_KEY_SET_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define UKST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ukst assertion failed");
`define UKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ukst assertion failed");
`else
`define UKST_ASSERT(lbl, clk, rstn, prop)
`define UKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/ukst_pkg.sv
// Shared constants and codes for the unique key set table.
// No dependencies.
package ukst_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

endpackage

// File: design/ukst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module ukst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/unique_key_set_table.sv
// Unique key set table: a table of up to CAPACITY distinct keys with add, remove (last entry
// moves into the freed slot), find and read-by-slot. Keys sit in a single-port-read RAM and a
// search reads one slot a cycle. A hit on a remove copies the last entry over the freed
// slot; a read of an out-of-range slot skips the RAM. One word is worked at a time. The next
// word is taken while the previous result waits in the output register; a result that finds
// that register still full holds the block until the receiver takes the waiting word.
module unique_key_set_table
  import ukst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [SLOT_W-1:0]    slot_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [SLOT_W-1:0]    found_slot_o,
  output logic [KEY_WIDTH-1:0] read_key_o,
  output logic [COUNT_W-1:0]   fill_count_o
);

`include "unique_key_set_table_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RDATA,
    S_MOVE,
    S_FINISH
  } state_e;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [COUNT_W-1:0]     idx_q, idx_d;
  logic [SLOT_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                   rvalid_q, rvalid_d;
  logic [SLOT_W-1:0]      pos_q, pos_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  status_e                res_status_q, res_status_d;
  logic [SLOT_W-1:0]      res_slot_q, res_slot_d;
  logic [KEY_WIDTH-1:0]   res_key_q, res_key_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [SLOT_W-1:0]      out_slot_q, out_slot_d;
  logic [KEY_WIDTH-1:0]   out_key_q, out_key_d;
  logic [COUNT_W-1:0]     out_count_q, out_count_d;

  logic                   mem_we, mem_re;
  logic [SLOT_W-1:0]      mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0]   mem_wdata, mem_rdata;
  logic                   hit;
  logic [COUNT_W-1:0]     last_idx;

  ukst_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign hit        = rvalid_q && (mem_rdata == key_q);
  assign last_idx   = count_q - COUNT_W'(1);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    idx_d        = idx_q;
    cmp_idx_d    = cmp_idx_q;
    rvalid_d     = rvalid_q;
    pos_d        = pos_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_key_d    = out_key_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[SLOT_W-1:0];
    mem_wdata    = key_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[SLOT_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(command_i);
          key_d        = key_i;
          res_status_d = ST_DONE;
          res_slot_d   = '0;
          res_key_d    = '0;
          if (cmd_e'(command_i) == CMD_READ) begin
            if ({1'b0, slot_i} < count_q) begin
              mem_re     = 1'b1;
              mem_raddr  = slot_i;
              res_slot_d = slot_i;
              state_d    = S_RDATA;
            end else begin
              res_status_d = ST_RANGE;
              state_d      = S_FINISH;
            end
          end else begin
            idx_d    = '0;
            rvalid_d = 1'b0;
            state_d  = S_SEARCH;
          end
        end
      end
      // One read issued per cycle; each compare is made in the cycle after its read.
      S_SEARCH: begin
        if (hit) begin
          rvalid_d   = 1'b0;
          res_slot_d = cmp_idx_q;
          case (cmd_q)
            CMD_ADD: begin
              res_status_d = ST_PRESENT;
              state_d      = S_FINISH;
            end
            CMD_REMOVE: begin
              mem_re    = 1'b1;
              mem_raddr = last_idx[SLOT_W-1:0];
              pos_d     = cmp_idx_q;
              state_d   = S_MOVE;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end else if (idx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[SLOT_W-1:0];
          rvalid_d  = 1'b1;
          cmp_idx_d = idx_q[SLOT_W-1:0];
          idx_d     = idx_q + COUNT_W'(1);
        end else begin
          rvalid_d = 1'b0;
          if (!rvalid_q) begin
            // search exhausted without a match
            if (cmd_q == CMD_ADD) begin
              if (count_q >= COUNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                res_slot_d = count_q[SLOT_W-1:0];
                count_d    = count_q + COUNT_W'(1);
              end
            end else begin
              res_status_d = ST_ABSENT;
            end
            state_d = S_FINISH;
          end
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = mem_rdata;
        count_d   = last_idx;
        state_d   = S_FINISH;
      end
      S_RDATA: begin
        res_key_d = mem_rdata;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_key_d    = res_key_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_ADD;
      key_q        <= '0;
      idx_q        <= '0;
      cmp_idx_q    <= '0;
      rvalid_q     <= 1'b0;
      pos_q        <= '0;
      count_q      <= '0;
      res_status_q <= ST_DONE;
      res_slot_q   <= '0;
      res_key_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_slot_q   <= '0;
      out_key_q    <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      idx_q        <= idx_d;
      cmp_idx_q    <= cmp_idx_d;
      rvalid_q     <= rvalid_d;
      pos_q        <= pos_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_key_q    <= res_key_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_key_q    <= out_key_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_slot_o = out_slot_q;
  assign read_key_o   = out_key_q;
  assign fill_count_o = out_count_q;

  `UKST_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= COUNT_W'(CAPACITY))
  `UKST_ASSERT(a_write_states, clk_i, rst_ni,
               !mem_we || state_q == S_SEARCH || state_q == S_MOVE)
  `UKST_ASSERT(a_cmp_in_range, clk_i, rst_ni,
               !(state_q == S_SEARCH && rvalid_q) || ({1'b0, cmp_idx_q} < count_q))
  `UKST_ASSERT_NEXT(a_count_idle, clk_i, rst_ni, state_q == S_IDLE, count_q == $past(count_q))

endmodule
